// ----- sv/rbsi_pkg.sv -----
// shared types for the ray/box slab intersection core
// request and response payload structs; no dependencies
package rbsi_pkg;

	localparam int COORD_W = 32;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] origin_z;
		logic [COORD_W-1:0] dir_x;
		logic [COORD_W-1:0] dir_y;
		logic [COORD_W-1:0] dir_z;
		logic [COORD_W-1:0] box_min_x;
		logic [COORD_W-1:0] box_min_y;
		logic [COORD_W-1:0] box_min_z;
		logic [COORD_W-1:0] box_max_x;
		logic [COORD_W-1:0] box_max_y;
		logic [COORD_W-1:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] t_near;
		logic [COORD_W-1:0] t_far;
		logic               saturated;
	} rsp_t;

endpackage

// ----- sv/ray_box_slab_intersection_core.sv -----
// ray versus axis-aligned box slab test, fully pipelined, one box per cycle unless the output stalls
// depends on rbsi_pkg for the request and response structs
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  request | req_valid | req_stall | req     | into core
//  result  | rsp_valid | rsp_stall | rsp     | out of core
//
// one transfer per cycle on both sides while not held; the depth is set mostly by the
// 32-stage bit-per-stage square root and the 33-stage bit-per-stage dividers
// the whole pipeline advances together; it holds only while a result waits
// under rsp_stall, and then req_stall is raised in the same cycle
// reset clears only the valid bits; payload registers are not reset
module ray_box_slab_intersection_core
	import rbsi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 33;

	// per item context carried alongside the arithmetic
	typedef struct packed {
		logic [5:0][32:0] mag;     // |plane - origin|, planes 0..2 lower, 3..5 upper
		logic [5:0]       neg;     // sign of (plane - origin) / dir
		logic [2:0][31:0] dm;      // |dir| per axis
		logic [2:0]       dz;      // dir component is zero
		logic             outside; // zero component with origin off the slab
		logic             zero;    // whole direction vector is zero
	} ctx_t;

	logic en;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// ---------------------------------------------------------------- stage 1
	// slab offsets, magnitudes and signs
	logic signed [31:0] o_w [3];
	logic signed [31:0] d_w [3];
	logic signed [31:0] lo_w [3];
	logic signed [31:0] hi_w [3];
	ctx_t ctx_w;

	always_comb begin
		logic signed [32:0] dlo;
		logic signed [32:0] dhi;
		o_w[0]  = req.origin_x;  o_w[1]  = req.origin_y;  o_w[2]  = req.origin_z;
		d_w[0]  = req.dir_x;     d_w[1]  = req.dir_y;     d_w[2]  = req.dir_z;
		lo_w[0] = req.box_min_x; lo_w[1] = req.box_min_y; lo_w[2] = req.box_min_z;
		hi_w[0] = req.box_max_x; hi_w[1] = req.box_max_y; hi_w[2] = req.box_max_z;
		ctx_w = '0;
		for (int a = 0; a < 3; a++) begin
			dlo = 33'(lo_w[a]) - 33'(o_w[a]);
			dhi = 33'(hi_w[a]) - 33'(o_w[a]);
			ctx_w.mag[a]   = dlo[32] ? 33'(-dlo) : 33'(dlo);
			ctx_w.mag[a+3] = dhi[32] ? 33'(-dhi) : 33'(dhi);
			ctx_w.neg[a]   = dlo[32] ^ d_w[a][31];
			ctx_w.neg[a+3] = dhi[32] ^ d_w[a][31];
			ctx_w.dm[a]    = d_w[a][31] ? 32'(-d_w[a]) : 32'(d_w[a]);
			ctx_w.dz[a]    = (d_w[a] == 32'sd0);
			if (ctx_w.dz[a] && (o_w[a] < lo_w[a] || o_w[a] > hi_w[a])) begin
				ctx_w.outside = 1'b1;
			end
		end
	end

	logic v_s1;
	ctx_t ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_w;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// squares of the direction magnitudes, one multiplier per axis
	logic             v_s2;
	ctx_t             ctx_s2;
	logic [2:0][63:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= 64'(ctx_s1.dm[a]) * 64'(ctx_s1.dm[a]);
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	// squared length; at most 3 * 2^62, fits 64 bits
	logic        v_s3;
	ctx_t        ctx_s3;
	logic [63:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] s;
		ctx_t        c;
		if (en) begin
			s = sq_s2[0] + sq_s2[1] + sq_s2[2];
			c = ctx_s2;
			c.zero = (s == 64'd0);
			sum_s3 <= s;
			ctx_s3 <= c;
		end
	end

	// ---------------------------------------------------------- square root
	// restoring integer square root, one root bit per stage, msb first
	logic [63:0] rem_sk  [SQ_STEPS+1];
	logic [31:0] root_sk [SQ_STEPS+1];
	ctx_t        ctx_sk  [SQ_STEPS+1];
	logic        v_sk    [SQ_STEPS+1];

	assign rem_sk[0]  = sum_s3;
	assign root_sk[0] = '0;
	assign ctx_sk[0]  = ctx_s3;
	assign v_sk[0]    = v_s3;

	for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
		localparam int K = SQ_STEPS - i;
		logic [65:0] trial;
		assign trial = (66'(root_sk[i-1]) << (K + 1)) | (66'd1 << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[i] <= 1'b0;
			end else if (en) begin
				v_sk[i] <= v_sk[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_sk[i] <= ctx_sk[i-1];
				if (66'(rem_sk[i-1]) >= trial) begin
					rem_sk[i]  <= rem_sk[i-1] - trial[63:0];
					root_sk[i] <= root_sk[i-1] | (32'd1 << K);
				end else begin
					rem_sk[i]  <= rem_sk[i-1];
					root_sk[i] <= root_sk[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 4
	// plane offset times length, one 33 x 32 multiplier per plane
	logic             v_s4;
	ctx_t             ctx_s4;
	logic [5:0][64:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sk[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_sk[SQ_STEPS];
			for (int j = 0; j < 6; j++) begin
				prod_s4[j] <= 65'(ctx_sk[SQ_STEPS].mag[j]) * 65'(root_sk[SQ_STEPS]);
			end
		end
	end

	// ---------------------------------------------------------------- stage 5
	// divider setup: any quotient of 2^33 or more saturates anyway
	logic [5:0][31:0] dv_rem  [DIV_STEPS+1];
	logic [5:0][32:0] dv_low  [DIV_STEPS+1];
	logic [5:0][32:0] dv_quo  [DIV_STEPS+1];
	logic [5:0]       dv_ovf  [DIV_STEPS+1];
	ctx_t             dv_ctx  [DIV_STEPS+1];
	logic             dv_v    [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ctx[0] <= ctx_s4;
			for (int j = 0; j < 6; j++) begin
				dv_ovf[0][j] <= (prod_s4[j][64:33] >= ctx_s4.dm[j % 3]);
				dv_rem[0][j] <= prod_s4[j][64:33];
				dv_low[0][j] <= prod_s4[j][32:0];
				dv_quo[0][j] <= '0;
			end
		end
	end

	// ---------------------------------------------------------- long division
	// one quotient bit per stage; remainder stays below the divisor when no overflow is flagged
	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i] <= 1'b0;
			end else if (en) begin
				dv_v[i] <= dv_v[i-1];
			end
		end

		always_ff @(posedge clk) begin
			logic [32:0] r;
			logic [32:0] dvs;
			if (en) begin
				dv_ctx[i] <= dv_ctx[i-1];
				dv_ovf[i] <= dv_ovf[i-1];
				for (int j = 0; j < 6; j++) begin
					r   = {dv_rem[i-1][j], dv_low[i-1][j][32]};
					dvs = {1'b0, dv_ctx[i-1].dm[j % 3]};
					dv_low[i][j] <= {dv_low[i-1][j][31:0], 1'b0};
					if (r >= dvs) begin
						dv_rem[i][j] <= 32'(r - dvs);
						dv_quo[i][j] <= {dv_quo[i-1][j][31:0], 1'b1};
					end else begin
						dv_rem[i][j] <= r[31:0];
						dv_quo[i][j] <= {dv_quo[i-1][j][31:0], 1'b0};
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 6
	// signed, pre-clipped distances; per axis entry and exit
	localparam logic signed [34:0] POS_LIM  = 35'sd2147483648;
	localparam logic signed [34:0] NEG_LIM  = -35'sd2147483649;
	localparam logic signed [34:0] NONE_LO  = -35'sd8589934592;
	localparam logic signed [34:0] NONE_HI  = 35'sd8589934592;

	logic                    v_s6;
	logic                    outside_s6;
	logic                    zero_s6;
	logic signed [2:0][34:0] enter_s6;
	logic signed [2:0][34:0] leave_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [34:0] t [6];
		logic [34:0] q;
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				q = 35'(dv_quo[DIV_STEPS][j]);
				if (q == 35'd0) begin
					t[j] = '0;
				end else if (dv_ctx[DIV_STEPS].neg[j]) begin
					if (dv_ovf[DIV_STEPS][j] || $signed(q) > -NEG_LIM) begin
						t[j] = NEG_LIM;
					end else begin
						t[j] = -$signed(q);
					end
				end else begin
					if (dv_ovf[DIV_STEPS][j] || $signed(q) > POS_LIM) begin
						t[j] = POS_LIM;
					end else begin
						t[j] = $signed(q);
					end
				end
			end
			for (int a = 0; a < 3; a++) begin
				if (dv_ctx[DIV_STEPS].dz[a]) begin
					enter_s6[a] <= NONE_LO;
					leave_s6[a] <= NONE_HI;
				end else if (t[a] < t[a+3]) begin
					enter_s6[a] <= t[a];
					leave_s6[a] <= t[a+3];
				end else begin
					enter_s6[a] <= t[a+3];
					leave_s6[a] <= t[a];
				end
			end
			outside_s6 <= dv_ctx[DIV_STEPS].outside;
			zero_s6    <= dv_ctx[DIV_STEPS].zero;
		end
	end

	// ---------------------------------------------------------- output stage
	// combine axes, clip to 32 bits, hit test on clipped values
	rsp_t rsp_q;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [34:0] nr;
		logic signed [34:0] fr;
		logic               clip;
		logic signed [31:0] nc;
		logic signed [31:0] fc;
		if (en) begin
			nr = enter_s6[0];
			fr = leave_s6[0];
			for (int a = 1; a < 3; a++) begin
				if ($signed(enter_s6[a]) > nr) begin
					nr = enter_s6[a];
				end
				if ($signed(leave_s6[a]) < fr) begin
					fr = leave_s6[a];
				end
			end
			clip = 1'b0;
			if (nr > 35'sd2147483647) begin
				nc = 32'sh7fffffff; clip = 1'b1;
			end else if (nr < -35'sd2147483648) begin
				nc = 32'sh80000000; clip = 1'b1;
			end else begin
				nc = nr[31:0];
			end
			if (fr > 35'sd2147483647) begin
				fc = 32'sh7fffffff; clip = 1'b1;
			end else if (fr < -35'sd2147483648) begin
				fc = 32'sh80000000; clip = 1'b1;
			end else begin
				fc = fr[31:0];
			end
			if (zero_s6) begin
				rsp_q <= '0;
			end else begin
				rsp_q.hit       <= !outside_s6 && nc >= 32'sd0 && nc < fc;
				rsp_q.t_near    <= nc;
				rsp_q.t_far     <= fc;
				rsp_q.saturated <= clip;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// ---------------------------------------------------------- assertions
	// a reported hit always has an ordered, non-negative interval
	a_hit_interval: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |->
			$signed(rsp.t_near) >= 0 && $signed(rsp.t_near) < $signed(rsp.t_far))
		else $error("hit reported with an empty or negative interval");

	// a zero direction vector has a zero root out of the sqrt pipe
	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		v_sk[SQ_STEPS] && ctx_sk[SQ_STEPS].zero |-> root_sk[SQ_STEPS] == 32'd0)
		else $error("nonzero root for a zero direction");

	// divider remainder stays below the divisor on plane 0 when its axis is live and without overflow
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[DIV_STEPS] && !dv_ctx[DIV_STEPS].dz[0] && !dv_ovf[DIV_STEPS][0] |->
			dv_rem[DIV_STEPS][0] < dv_ctx[DIV_STEPS].dm[0])
		else $error("divider remainder out of range");

	// a zero direction vector never yields a hit at the output stage
	a_zero_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && zero_s6 && en |=> !rsp.hit && !rsp.saturated)
		else $error("zero direction produced a hit");

endmodule
